>>> src/lhre_pkg.sv
// Shared types, codes and constants of the link health recovery escalator.
package lhre_pkg;

  localparam int TIME_WIDTH = 48;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // Register reset values, also taken when a zero is written
  localparam logic [31:0] RST_PROBE_INTERVAL  = 32'd15000;
  localparam logic [7:0]  RST_FAIL_LIMIT      = 8'd3;
  localparam logic [31:0] RST_REASSOC_GRACE   = 32'd30000;
  localparam logic [31:0] RST_IFACE_DOWN_TIME = 32'd1000;
  localparam logic [31:0] RST_IFACE_GRACE     = 32'd45000;

  typedef enum logic [2:0] {
    REG_PROBE_INTERVAL  = 3'd0,
    REG_FAIL_LIMIT      = 3'd1,
    REG_REASSOC_GRACE   = 3'd2,
    REG_IFACE_DOWN_TIME = 3'd3,
    REG_IFACE_GRACE     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] probe_interval;
    logic [7:0]  fail_limit;
    logic [31:0] reassoc_grace;
    logic [31:0] iface_down_time;
    logic [31:0] iface_grace;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PROBE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PRB_UNAVAILABLE = 2'd0,
    PRB_REACHABLE   = 2'd1,
    PRB_UNREACHABLE = 2'd2
  } probe_res_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_PROBE   = 3'd1,
    ACT_REASSOC = 3'd2,
    ACT_DOWN    = 3'd3,
    ACT_UP      = 3'd4,
    ACT_REBOOT  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    CONN_DISCONNECTED = 3'd0,
    CONN_RECOVERING   = 3'd1,
    CONN_HEALTHY      = 3'd2,
    CONN_DEGRADED     = 3'd3,
    CONN_UNKNOWN      = 3'd4
  } conn_t;

  typedef enum logic [2:0] {
    STG_NONE       = 3'd0,
    STG_REASSOC    = 3'd1,
    STG_IFACE      = 3'd2,
    STG_REBOOT_PND = 3'd3,
    STG_REBOOT_REQ = 3'd4,
    STG_EXHAUSTED  = 3'd5
  } stage_t;

  localparam logic signed [1:0] REACH_UNKNOWN     = -2'sd1;
  localparam logic signed [1:0] REACH_UNREACHABLE = 2'sd0;
  localparam logic signed [1:0] REACH_REACHABLE   = 2'sd1;

endpackage

>>> src/lhre_if.sv
// Event and result channel interfaces of the link health recovery escalator.
interface lhre_evt_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [lhre_pkg::TIME_WIDTH-1:0]   now_time;
  logic                              link_associated;
  logic                              route_present;
  logic [1:0]                        probe_outcome;
  logic                              reboot_submitted;

  modport source (
    output valid, cmd, now_time, link_associated, route_present, probe_outcome,
           reboot_submitted,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_time, link_associated, route_present, probe_outcome,
           reboot_submitted,
    output ready
  );
endinterface

interface lhre_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [2:0]        connectivity;
  logic [2:0]        recovery_stage;
  logic signed [1:0] gateway_state;
  logic [7:0]        failure_count;
  logic              reboot_flag;

  modport source (
    output valid, action, connectivity, recovery_stage, gateway_state, failure_count,
           reboot_flag,
    input  ready
  );
  modport sink (
    input  valid, action, connectivity, recovery_stage, gateway_state, failure_count,
           reboot_flag,
    output ready
  );
endinterface

>>> src/lhre_regs.sv
// APB configuration register bank of the link health recovery escalator.
module lhre_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lhre_pkg::PADDR_W-1:0]  paddr,
  input  logic [lhre_pkg::PDATA_W-1:0]  pwdata,
  output logic [lhre_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lhre_pkg::cfg_t                cfg
);

  logic                 wr_en;
  lhre_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = lhre_pkg::reg_idx_t'(paddr[4:2]);

  // Zero is not a legal setting: fall back to the reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_interval  <= lhre_pkg::RST_PROBE_INTERVAL;
      cfg.fail_limit      <= lhre_pkg::RST_FAIL_LIMIT;
      cfg.reassoc_grace   <= lhre_pkg::RST_REASSOC_GRACE;
      cfg.iface_down_time <= lhre_pkg::RST_IFACE_DOWN_TIME;
      cfg.iface_grace     <= lhre_pkg::RST_IFACE_GRACE;
    end else if (wr_en) begin
      unique case (idx)
        lhre_pkg::REG_PROBE_INTERVAL: begin
          cfg.probe_interval <= (pwdata != '0) ? pwdata : lhre_pkg::RST_PROBE_INTERVAL;
        end
        lhre_pkg::REG_FAIL_LIMIT: begin
          cfg.fail_limit <= (pwdata[7:0] != '0) ? pwdata[7:0] : lhre_pkg::RST_FAIL_LIMIT;
        end
        lhre_pkg::REG_REASSOC_GRACE: begin
          cfg.reassoc_grace <= (pwdata != '0) ? pwdata : lhre_pkg::RST_REASSOC_GRACE;
        end
        lhre_pkg::REG_IFACE_DOWN_TIME: begin
          cfg.iface_down_time <= (pwdata != '0) ? pwdata : lhre_pkg::RST_IFACE_DOWN_TIME;
        end
        lhre_pkg::REG_IFACE_GRACE: begin
          cfg.iface_grace <= (pwdata != '0) ? pwdata : lhre_pkg::RST_IFACE_GRACE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lhre_pkg::REG_PROBE_INTERVAL:  prdata = cfg.probe_interval;
      lhre_pkg::REG_FAIL_LIMIT:      prdata = {24'd0, cfg.fail_limit};
      lhre_pkg::REG_REASSOC_GRACE:   prdata = cfg.reassoc_grace;
      lhre_pkg::REG_IFACE_DOWN_TIME: prdata = cfg.iface_down_time;
      lhre_pkg::REG_IFACE_GRACE:     prdata = cfg.iface_grace;
      default:                       prdata = '0;
    endcase
  end

endmodule

>>> src/link_health_recovery_escalator.sv
// Top level of the link health recovery escalator: event stage, state update, result register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------------
//   evt      | in  | valid/ready        | cmd, now_time, link_associated, route_present,
//            |     |                    | probe_outcome, reboot_submitted
//   res      | out | valid/ready        | action, connectivity, recovery_stage,
//            |     |                    | gateway_state, failure_count, reboot_flag
//   apb      | in  | psel/penable/pready| paddr, pwdata, prdata (5 registers at 4*i)
//
// Every event yields exactly one result beat, passing through the event register and then the
// result register. One event enters per cycle: the event register feeds a single pass
// of compares, 48-bit adds and phase selection that updates the link state and loads
// the result register in the same edge. A stalled result holds the event register,
// and evt.ready falls only while both are full. Synchronous reset clears the phase,
// the times, the flags, the counters and the valid bits; the registers take defaults.
module link_health_recovery_escalator (
  input  logic                          clk,
  input  logic                          rst,
  lhre_evt_if.sink                      evt,
  lhre_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lhre_pkg::PADDR_W-1:0]  paddr,
  input  logic [lhre_pkg::PDATA_W-1:0]  pwdata,
  output logic [lhre_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int TW = lhre_pkg::TIME_WIDTH;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_REASSOC     = 3'd1,
    PH_DOWN_WAIT   = 3'd2,
    PH_IF_RECOVER  = 3'd3,
    PH_REBOOT_PEND = 3'd4,
    PH_REBOOT_REQ  = 3'd5,
    PH_EXHAUSTED   = 3'd6
  } phase_t;

  lhre_pkg::cfg_t cfg;

  // Event register
  logic          s1_valid;
  logic [1:0]    s1_cmd;
  logic [TW-1:0] s1_now;
  logic          s1_assoc;
  logic          s1_route;
  logic [1:0]    s1_outcome;
  logic          s1_submit;
  logic          s1_adv;

  // Link state
  phase_t            phase, phase_next;
  logic [TW-1:0]     next_probe_time, next_probe_time_next;
  logic [TW-1:0]     deadline, deadline_next;
  logic              assoc_seen, assoc_seen_next;
  logic              probe_out, probe_out_next;
  logic signed [1:0] reach, reach_next;
  logic [7:0]        fail_count, fail_count_next;
  logic              healthy_once, healthy_once_next;

  // Result register
  logic                  out_valid;
  lhre_pkg::action_t     act, out_action;
  lhre_pkg::conn_t       conn, out_conn;
  lhre_pkg::stage_t      stage, out_stage;
  logic signed [1:0]     out_reach;
  logic [7:0]            out_fail;
  logic                  out_reboot;

  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] a, input logic [31:0] b);
    return a + TW'(b);
  endfunction

  lhre_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the event into the result register whenever that register is free
  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
    if (evt.valid && evt.ready) begin
      s1_cmd     <= evt.cmd;
      s1_now     <= evt.now_time;
      s1_assoc   <= evt.link_associated;
      s1_route   <= evt.route_present;
      s1_outcome <= evt.probe_outcome;
      s1_submit  <= evt.reboot_submitted;
    end
  end

  // Single pass over one event: tick and finish handling, then the shared
  // probe-result path (a tick that is due for a probe but has no route counts as unreachable)
  always_comb begin
    logic       probe_en;
    logic [1:0] outcome;
    logic [7:0] fail_inc;

    phase_next           = phase;
    next_probe_time_next = next_probe_time;
    deadline_next        = deadline;
    assoc_seen_next      = assoc_seen;
    probe_out_next       = probe_out;
    reach_next           = reach;
    fail_count_next      = fail_count;
    healthy_once_next    = healthy_once;
    act                  = lhre_pkg::ACT_NONE;
    probe_en             = 1'b0;
    outcome              = s1_outcome;

    unique case (lhre_pkg::cmd_t'(s1_cmd))
      lhre_pkg::CMD_TICK: begin
        if (phase == PH_REBOOT_PEND || phase == PH_REBOOT_REQ) begin
          act = lhre_pkg::ACT_NONE;
        end else if (phase == PH_DOWN_WAIT) begin
          if (s1_now >= deadline) begin
            phase_next           = PH_IF_RECOVER;
            next_probe_time_next = tadd(s1_now, cfg.iface_grace);
            act                  = lhre_pkg::ACT_UP;
          end
        end else if (phase != PH_REASSOC && phase != PH_IF_RECOVER && !s1_assoc) begin
          // Link lost: drop back to a clean disconnected state
          phase_next           = PH_IDLE;
          next_probe_time_next = tadd(s1_now, cfg.probe_interval);
          deadline_next        = '0;
          assoc_seen_next      = 1'b0;
          probe_out_next       = 1'b0;
          reach_next           = lhre_pkg::REACH_UNKNOWN;
          fail_count_next      = '0;
          healthy_once_next    = 1'b0;
        end else begin
          if (s1_assoc && !assoc_seen) begin
            assoc_seen_next      = 1'b1;
            next_probe_time_next = s1_now;
          end
          if (!probe_out && s1_now >= next_probe_time_next) begin
            if (!s1_route) begin
              probe_en = 1'b1;
              outcome  = lhre_pkg::PRB_UNREACHABLE;
            end else begin
              probe_out_next = 1'b1;
              act            = lhre_pkg::ACT_PROBE;
            end
          end
        end
      end
      lhre_pkg::CMD_PROBE: begin
        probe_en = 1'b1;
      end
      lhre_pkg::CMD_FINISH: begin
        if (phase == PH_REBOOT_PEND) begin
          phase_next = s1_submit ? PH_REBOOT_REQ : PH_EXHAUSTED;
        end
      end
      default: begin
      end
    endcase

    fail_inc = (fail_count < cfg.fail_limit) ? fail_count + 8'd1 : fail_count;

    if (probe_en) begin
      probe_out_next       = 1'b0;
      next_probe_time_next = tadd(s1_now, cfg.probe_interval);
      priority case (outcome)
        lhre_pkg::PRB_UNAVAILABLE: begin
          reach_next      = lhre_pkg::REACH_UNKNOWN;
          fail_count_next = '0;
        end
        lhre_pkg::PRB_REACHABLE: begin
          reach_next        = lhre_pkg::REACH_REACHABLE;
          fail_count_next   = '0;
          healthy_once_next = 1'b1;
          phase_next        = PH_IDLE;
          deadline_next     = '0;
        end
        default: begin
          // Unreachable, and the unused outcome code with it: count a failure, escalate one step when due
          reach_next      = lhre_pkg::REACH_UNREACHABLE;
          fail_count_next = fail_inc;
          if (phase == PH_IDLE && healthy_once && fail_inc >= cfg.fail_limit) begin
            phase_next           = PH_REASSOC;
            next_probe_time_next = tadd(s1_now, cfg.reassoc_grace);
            act                  = lhre_pkg::ACT_REASSOC;
          end else if (phase == PH_REASSOC) begin
            phase_next    = PH_DOWN_WAIT;
            deadline_next = tadd(s1_now, cfg.iface_down_time);
            act           = lhre_pkg::ACT_DOWN;
          end else if (phase == PH_IF_RECOVER) begin
            phase_next           = PH_REBOOT_PEND;
            next_probe_time_next = '0;
            act                  = lhre_pkg::ACT_REBOOT;
          end
        end
      endcase
    end
  end

  // Status codes from the state after this event
  always_comb begin
    priority if (!assoc_seen_next) begin
      conn = lhre_pkg::CONN_DISCONNECTED;
    end else if (phase_next != PH_IDLE) begin
      conn = lhre_pkg::CONN_RECOVERING;
    end else if (reach_next == lhre_pkg::REACH_REACHABLE) begin
      conn = lhre_pkg::CONN_HEALTHY;
    end else if (reach_next == lhre_pkg::REACH_UNREACHABLE || fail_count_next != '0) begin
      conn = lhre_pkg::CONN_DEGRADED;
    end else begin
      conn = lhre_pkg::CONN_UNKNOWN;
    end

    unique case (phase_next)
      PH_REASSOC:                  stage = lhre_pkg::STG_REASSOC;
      PH_DOWN_WAIT, PH_IF_RECOVER: stage = lhre_pkg::STG_IFACE;
      PH_REBOOT_PEND:              stage = lhre_pkg::STG_REBOOT_PND;
      PH_REBOOT_REQ:               stage = lhre_pkg::STG_REBOOT_REQ;
      PH_EXHAUSTED:                stage = lhre_pkg::STG_EXHAUSTED;
      default:                     stage = lhre_pkg::STG_NONE;
    endcase
  end

  // Commit state and load the result beat together
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      next_probe_time <= '0;
      deadline        <= '0;
      assoc_seen      <= 1'b0;
      probe_out       <= 1'b0;
      reach           <= lhre_pkg::REACH_UNKNOWN;
      fail_count      <= '0;
      healthy_once    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase           <= phase_next;
        next_probe_time <= next_probe_time_next;
        deadline        <= deadline_next;
        assoc_seen      <= assoc_seen_next;
        probe_out       <= probe_out_next;
        reach           <= reach_next;
        fail_count      <= fail_count_next;
        healthy_once    <= healthy_once_next;
        out_valid       <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_action <= act;
      out_conn   <= conn;
      out_stage  <= stage;
      out_reach  <= reach_next;
      out_fail   <= fail_count_next;
      out_reboot <= (phase_next == PH_REBOOT_REQ);
    end
  end

  assign res.valid          = out_valid;
  assign res.action         = out_action;
  assign res.connectivity   = out_conn;
  assign res.recovery_stage = out_stage;
  assign res.gateway_state  = out_reach;
  assign res.failure_count  = out_fail;
  assign res.reboot_flag    = out_reboot;

endmodule
